>>> hw/rtl/fpb_pkg.sv
`timescale 1ns / 1ps

package fpb_pkg;

    localparam int STATES_MAX_DEF = 20;
    localparam int WORD_BITS_DEF  = 32;

    localparam int STATE_IDX_W  = 5;
    localparam int SCORE_W      = 32;
    localparam int NUM_STATES_W = 5;
    localparam int CFG_ADDR_W   = 1;
    localparam int CFG_DATA_W   = 32;

    localparam logic [NUM_STATES_W-1:0] NUM_STATES_RST = NUM_STATES_W'(4);

    // register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_STATES = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_CONST_COST = CFG_ADDR_W'(1);

    // request kinds carried in s_tuser
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_EDGE   = 1'b1;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } store_ctrl_t;

endpackage

>>> hw/rtl/fitch_parsimony_bitvector_top.sv
`timescale 1ns / 1ps
// Bit-parallel Fitch parsimony step. One word per character state is taken per cycle
// while a word position is collected; AND and OR of each state go into two small
// memories (one write port, one read port) and the OR of all ANDs builds up in a register.
// After the word that completes a position the block stops accepting: it counts the empty
// intersections, then forms the running total and score. In update mode each parent word then
// goes through memory read, combine and the output register, plus any wait on m_tready.
// In edge mode the block goes back to collecting, but for the last word of the vector, the
// only one with a result, which waits in the output register for m_tready.

module fitch_parsimony_bitvector_top import fpb_pkg::*; #(
    parameter int STATES_MAX = STATES_MAX_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF,
    localparam int S_DATA_W  = ((2 * WORD_BITS + 2 * SCORE_W + 7) / 8) * 8,
    localparam int M_DATA_W  = ((WORD_BITS + STATE_IDX_W + SCORE_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // left_bits, right_bits, left_cost, right_cost
    input  logic [S_DATA_W-1:0]   s_tdata,
    // req_type
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // parent_bits, state_index, score
    output logic [M_DATA_W-1:0]   m_tdata,
    // score_valid
    output logic                  m_tuser,
    output logic                  m_tlast
);

    localparam int IW = (STATES_MAX > 1) ? $clog2(STATES_MAX) : 1;
    localparam int CW = $clog2(STATES_MAX + 1);
    localparam int NW = (CW > NUM_STATES_W) ? CW : NUM_STATES_W;
    localparam int PW = $clog2(WORD_BITS + 1);
    localparam int NB = (WORD_BITS + 7) / 8;

    localparam logic [2:0] ST_COLLECT = 3'd0;
    localparam logic [2:0] ST_COUNT   = 3'd1;
    localparam logic [2:0] ST_TOTAL   = 3'd2;
    localparam logic [2:0] ST_READ    = 3'd3;
    localparam logic [2:0] ST_LOAD    = 3'd4;
    localparam logic [2:0] ST_HOLD    = 3'd5;

    // count of zero sites: per-byte counts, then a short sum over the bytes
    function automatic logic [PW-1:0] count_empty(input logic [WORD_BITS-1:0] u);
        logic [NB*8-1:0] v;
        logic [3:0]      c;
        logic [PW-1:0]   total;
        v = (NB*8)'(~u);
        total = '0;
        for (int b = 0; b < NB; b++) begin
            c = '0;
            for (int j = 0; j < 8; j++) begin
                c = c + 4'(v[b*8+j]);
            end
            total = total + PW'(c);
        end
        return total;
    endfunction

    // input fields
    logic [WORD_BITS-1:0] in_left;
    logic [WORD_BITS-1:0] in_right;
    logic [SCORE_W-1:0]   in_lcost;
    logic [SCORE_W-1:0]   in_rcost;
    assign in_left  = s_tdata[WORD_BITS-1:0];
    assign in_right = s_tdata[2*WORD_BITS-1:WORD_BITS];
    assign in_lcost = s_tdata[2*WORD_BITS+SCORE_W-1:2*WORD_BITS];
    assign in_rcost = s_tdata[2*WORD_BITS+2*SCORE_W-1:2*WORD_BITS+SCORE_W];

    // configuration
    logic [NUM_STATES_W-1:0] num_states_reg;
    logic [SCORE_W-1:0]      const_cost_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_states_reg <= NUM_STATES_RST;
            const_cost_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_NUM_STATES: num_states_reg <= cfg_wdata[NUM_STATES_W-1:0];
                REG_CONST_COST: const_cost_reg <= cfg_wdata[SCORE_W-1:0];
                default: ;
            endcase
        end
    end

    logic [NW-1:0] n_raw;
    logic [NW-1:0] n_eff;
    assign n_raw = NW'(num_states_reg);
    always_comb begin
        if (n_raw < NW'(2)) begin
            n_eff = NW'(2);
        end else if (n_raw > NW'(STATES_MAX)) begin
            n_eff = NW'(STATES_MAX);
        end else begin
            n_eff = n_raw;
        end
    end

    // control and datapath registers
    logic [2:0]           state_reg, state_next;
    logic [IW-1:0]        cnt_reg, cnt_next;
    logic [IW-1:0]        last_idx_reg, last_idx_next;
    logic [IW-1:0]        rd_idx_reg, rd_idx_next;
    logic [WORD_BITS-1:0] union_reg, union_next;
    logic [SCORE_W-1:0]   mismatch_reg, mismatch_next;
    logic                 edge_reg, edge_next;
    logic                 wlast_reg, wlast_next;
    logic [SCORE_W-1:0]   cost_sum_reg, cost_sum_next;
    logic [PW-1:0]        pop_reg, pop_next;
    logic [SCORE_W-1:0]   score_reg, score_next;

    logic [WORD_BITS-1:0]   o_parent_reg, o_parent_next;
    logic [STATE_IDX_W-1:0] o_idx_reg, o_idx_next;
    logic [SCORE_W-1:0]     o_score_reg, o_score_next;
    logic                   o_valid_reg, o_valid_next;
    logic                   o_last_reg, o_last_next;

    logic                 s_acc;
    logic                 pos_done;
    logic [WORD_BITS-1:0] and_word;
    logic [WORD_BITS-1:0] and_q;
    logic [WORD_BITS-1:0] or_q;
    logic [SCORE_W-1:0]   mis_sum;
    logic                 final_k;
    store_ctrl_t          st_ctrl;

    assign s_tready = (state_reg == ST_COLLECT);
    assign m_tvalid = (state_reg == ST_HOLD);
    assign s_acc    = s_tvalid && s_tready;
    assign and_word = in_left & in_right;
    assign pos_done = (NW'(cnt_reg) + NW'(1)) >= n_eff;
    assign mis_sum  = mismatch_reg + SCORE_W'(pop_reg);
    assign final_k  = (rd_idx_reg == last_idx_reg);

    assign st_ctrl.wr_en = s_acc;
    assign st_ctrl.rd_en = (state_reg == ST_READ);

    fpb_store #(
        .STATES_MAX(STATES_MAX),
        .WORD_BITS (WORD_BITS)
    ) u_store (
        .aclk   (aclk),
        .ctrl   (st_ctrl),
        .wr_addr(cnt_reg),
        .and_in (and_word),
        .or_in  (in_left | in_right),
        .rd_addr(rd_idx_reg),
        .and_q  (and_q),
        .or_q   (or_q)
    );

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        last_idx_next = last_idx_reg;
        rd_idx_next   = rd_idx_reg;
        union_next    = union_reg;
        mismatch_next = mismatch_reg;
        edge_next     = edge_reg;
        wlast_next    = wlast_reg;
        cost_sum_next = cost_sum_reg;
        pop_next      = pop_reg;
        score_next    = score_reg;
        o_parent_next = o_parent_reg;
        o_idx_next    = o_idx_reg;
        o_score_next  = o_score_reg;
        o_valid_next  = o_valid_reg;
        o_last_next   = o_last_reg;
        case (state_reg)
            ST_COLLECT: begin
                if (s_acc) begin
                    union_next = union_reg | and_word;
                    if (pos_done) begin
                        cnt_next      = '0;
                        last_idx_next = IW'(n_eff - NW'(1));
                        edge_next     = (s_tuser == REQ_EDGE);
                        wlast_next    = s_tlast;
                        cost_sum_next = in_lcost + in_rcost
                                      + ((s_tuser == REQ_EDGE) ? const_cost_reg : '0);
                        state_next    = ST_COUNT;
                    end else begin
                        cnt_next = cnt_reg + IW'(1);
                    end
                end
            end
            ST_COUNT: begin
                pop_next   = count_empty(union_reg);
                state_next = ST_TOTAL;
            end
            ST_TOTAL: begin
                score_next    = mis_sum + cost_sum_reg;
                mismatch_next = wlast_reg ? '0 : mis_sum;
                rd_idx_next   = '0;
                if (!edge_reg) begin
                    state_next = ST_READ;
                end else if (wlast_reg) begin
                    o_parent_next = '0;
                    o_idx_next    = '0;
                    o_score_next  = mis_sum + cost_sum_reg;
                    o_valid_next  = 1'b1;
                    o_last_next   = 1'b1;
                    rd_idx_next   = last_idx_reg;
                    state_next    = ST_HOLD;
                end else begin
                    union_next = '0;
                    state_next = ST_COLLECT;
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                o_parent_next = and_q | (or_q & ~union_reg);
                o_idx_next    = STATE_IDX_W'(rd_idx_reg);
                o_valid_next  = final_k && wlast_reg;
                o_score_next  = (final_k && wlast_reg) ? score_reg : '0;
                o_last_next   = final_k;
                state_next    = ST_HOLD;
            end
            ST_HOLD: begin
                if (m_tready) begin
                    if (final_k) begin
                        union_next = '0;
                        state_next = ST_COLLECT;
                    end else begin
                        rd_idx_next = rd_idx_reg + IW'(1);
                        state_next  = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_COLLECT;
            cnt_reg      <= '0;
            union_reg    <= '0;
            mismatch_reg <= '0;
            rd_idx_reg   <= '0;
            last_idx_reg <= '0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            union_reg    <= union_next;
            mismatch_reg <= mismatch_next;
            rd_idx_reg   <= rd_idx_next;
            last_idx_reg <= last_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        edge_reg     <= edge_next;
        wlast_reg    <= wlast_next;
        cost_sum_reg <= cost_sum_next;
        pop_reg      <= pop_next;
        score_reg    <= score_next;
        o_parent_reg <= o_parent_next;
        o_idx_reg    <= o_idx_next;
        o_score_reg  <= o_score_next;
        o_valid_reg  <= o_valid_next;
        o_last_reg   <= o_last_next;
    end

    assign m_tdata = M_DATA_W'({o_score_reg, o_idx_reg, o_parent_reg});
    assign m_tuser = o_valid_reg;
    assign m_tlast = o_last_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a result word is pending");

    a_done_to_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && pos_done) |=> (state_reg == ST_COUNT))
        else $error("completed position did not start the count");

    a_score_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("score word is not the last of its run");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (NW'(cnt_reg) < NW'(STATES_MAX)) && (NW'(rd_idx_reg) < NW'(STATES_MAX)))
        else $error("state index outside the store");

    a_union_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (union_reg == '0))
        else $error("union not cleared after a run");

endmodule

>>> hw/rtl/fpb_store.sv
`timescale 1ns / 1ps

module fpb_store import fpb_pkg::*; #(
    parameter int STATES_MAX = STATES_MAX_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF,
    localparam int IW = (STATES_MAX > 1) ? $clog2(STATES_MAX) : 1
) (
    input  logic                 aclk,
    input  store_ctrl_t          ctrl,
    input  logic [IW-1:0]        wr_addr,
    input  logic [WORD_BITS-1:0] and_in,
    input  logic [WORD_BITS-1:0] or_in,
    input  logic [IW-1:0]        rd_addr,
    output logic [WORD_BITS-1:0] and_q,
    output logic [WORD_BITS-1:0] or_q
);

    logic [WORD_BITS-1:0] and_mem [STATES_MAX];
    logic [WORD_BITS-1:0] or_mem  [STATES_MAX];

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            and_mem[wr_addr] <= and_in;
            or_mem[wr_addr]  <= or_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            and_q <= and_mem[rd_addr];
            or_q  <= or_mem[rd_addr];
        end
    end

endmodule

>>> tb/sv/tb_fitch_parsimony_bitvector_top.sv
`timescale 1ns / 1ps

module tb_fitch_parsimony_bitvector_top;
    import fpb_pkg::*;

    localparam int S_W = ((2 * WORD_BITS_DEF + 2 * SCORE_W + 7) / 8) * 8;
    localparam int M_W = ((WORD_BITS_DEF + STATE_IDX_W + SCORE_W + 7) / 8) * 8;
    localparam int ITEMS_PER_PHASE = 31;
    localparam int PHASES = 7;
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic        req;
        logic [31:0] left_bits;
        logic [31:0] right_bits;
        logic        word_last;
        logic [31:0] left_cost;
        logic [31:0] right_cost;
    } site_word_t;

    typedef struct packed {
        logic [31:0] parent_bits;
        logic [4:0]  state_index;
        logic [31:0] score;
        logic        score_valid;
        logic        last;
    } parent_word_t;

    // score typed in by hand for rows whose result is obvious
    typedef struct packed {
        logic        pinned;
        logic [31:0] score;
    } score_pin_t;

    typedef struct packed {
        site_word_t  w;
        logic        pinned;
        logic [31:0] pin_score;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_W-1:0]        s_tdata;
    logic                  s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_W-1:0]        m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    fitch_parsimony_bitvector_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // predictor state
    logic [4:0]  cfg_states = NUM_STATES_RST;
    logic [31:0] cfg_const_cost = '0;
    logic [31:0] and_words [STATES_MAX_DEF];
    logic [31:0] or_words [STATES_MAX_DEF];
    logic [31:0] common_sites = '0;
    int          state_pos = 0;
    logic [31:0] empty_sites = '0;

    parent_word_t parent_words_due[$];
    score_pin_t   score_pins[$];

    int  errors = 0;
    int  words_sent = 0;
    int  words_checked = 0;
    int  scores_checked = 0;
    int  settings_used = 1;
    int  cycles = 0;
    bit  no_stall = 0;

    dir_row_t directed_rows [20] = '{
        // all sites agree: no mismatch, score is the two costs (zero)
        '{'{REQ_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0}, 1'b0, 32'h0},
        '{'{REQ_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0}, 1'b0, 32'h0},
        '{'{REQ_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0}, 1'b0, 32'h0},
        '{'{REQ_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, 32'h0}, 1'b1, 32'h0},
        // every intersection empty: 32 mismatches, costs at max wrap to 30
        '{'{REQ_EDGE, 32'h0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, 32'h0},
        '{'{REQ_EDGE, 32'h0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, 32'h0},
        '{'{REQ_EDGE, 32'h0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, 32'h0},
        '{'{REQ_EDGE, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, 32'd30},
        // update word in the middle of a vector
        '{'{REQ_UPDATE, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, 32'h0, 32'h0}, 1'b0, 32'h0},
        '{'{REQ_UPDATE, 32'hFFFF_0000, 32'h0000_FFFF, 1'b0, 32'h0, 32'h0}, 1'b0, 32'h0},
        '{'{REQ_UPDATE, 32'h8000_0001, 32'h8000_0001, 1'b0, 32'h0, 32'h0}, 1'b0, 32'h0},
        '{'{REQ_UPDATE, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0}, 1'b0, 32'h0},
        // edge word in the middle of a vector: silent
        '{'{REQ_EDGE, 32'h1234_5678, 32'h8765_4321, 1'b0, 32'h11, 32'h22}, 1'b0, 32'h0},
        '{'{REQ_EDGE, 32'hDEAD_BEEF, 32'h0F0F_0F0F, 1'b0, 32'h33, 32'h44}, 1'b0, 32'h0},
        '{'{REQ_EDGE, 32'h0000_0001, 32'hFFFF_FFFE, 1'b0, 32'h55, 32'h66}, 1'b0, 32'h0},
        '{'{REQ_EDGE, 32'hF0F0_F0F0, 32'hF000_000F, 1'b0, 32'h77, 32'h88}, 1'b0, 32'h0},
        // mode and last flag only count on the word that completes the position
        '{'{REQ_EDGE, 32'h0000_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h9, 32'h9}, 1'b0, 32'h0},
        '{'{REQ_EDGE, 32'hFF00_FF00, 32'h00FF_FF00, 1'b1, 32'h9, 32'h9}, 1'b0, 32'h0},
        '{'{REQ_EDGE, 32'hCAFE_F00D, 32'h3C3C_3C3C, 1'b1, 32'h9, 32'h9}, 1'b0, 32'h0},
        '{'{REQ_UPDATE, 32'h7FFF_FFFE, 32'h8000_0001, 1'b1, 32'h7, 32'h100}, 1'b0, 32'h0}
    };

    logic [4:0] phase_states [PHASES] = '{5'd0, 5'd31, 5'd20, 5'd2, 5'd1, 5'd4, 5'd9};

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic predict_parent_words(input site_word_t w);
        int          n;
        int          idx;
        logic [31:0] total;
        parent_word_t r;
        n = (cfg_states < 2) ? 2 : ((cfg_states > STATES_MAX_DEF) ? STATES_MAX_DEF
                                                                  : int'(cfg_states));
        idx = (state_pos >= STATES_MAX_DEF) ? STATES_MAX_DEF - 1 : state_pos;
        and_words[idx] = w.left_bits & w.right_bits;
        or_words[idx] = w.left_bits | w.right_bits;
        common_sites = common_sites | (w.left_bits & w.right_bits);
        if (idx + 1 < n) begin
            state_pos = idx + 1;
        end else begin
            empty_sites = empty_sites + 32'($countones(~common_sites));
            total = '0;
            if (w.word_last) begin
                total = empty_sites + w.left_cost + w.right_cost;
                if (w.req == REQ_EDGE)
                    total = total + cfg_const_cost;
            end
            if (w.req == REQ_EDGE) begin
                if (w.word_last) begin
                    r = '{32'h0, 5'd0, total, 1'b1, 1'b1};
                    parent_words_due.push_back(r);
                end
            end else begin
                for (int k = 0; k < n; k++) begin
                    r.parent_bits = and_words[k] | (or_words[k] & ~common_sites);
                    r.state_index = 5'(k);
                    r.last = (k + 1 == n);
                    r.score_valid = r.last && w.word_last;
                    r.score = r.score_valid ? total : 32'h0;
                    parent_words_due.push_back(r);
                end
            end
            common_sites = '0;
            state_pos = 0;
            if (w.word_last)
                empty_sites = '0;
        end
    endtask

    always @(posedge aclk) begin : monitor
        site_word_t   w;
        score_pin_t   pin;
        parent_word_t due;
        parent_word_t got;
        int           due_count;
        if (aresetn) begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_NUM_STATES: cfg_states = cfg_wdata[4:0];
                    REG_CONST_COST: cfg_const_cost = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                w.req = s_tuser;
                w.word_last = s_tlast;
                {w.right_cost, w.left_cost, w.right_bits, w.left_bits} = s_tdata;
                pin = score_pins.pop_front();
                due_count = parent_words_due.size();
                predict_parent_words(w);
                if (pin.pinned && parent_words_due.size() > due_count) begin
                    due = parent_words_due.pop_back();
                    due.score = pin.score;
                    parent_words_due.push_back(due);
                end
                words_sent++;
            end
            if (m_tvalid && m_tready) begin
                got.parent_bits = m_tdata[31:0];
                got.state_index = m_tdata[36:32];
                got.score = m_tdata[68:37];
                got.score_valid = m_tuser;
                got.last = m_tlast;
                if (parent_words_due.size() == 0) begin
                    $error("result word with nothing expected: %h", m_tdata);
                    errors++;
                end else begin
                    due = parent_words_due.pop_front();
                    words_checked++;
                    if (due.score_valid)
                        scores_checked++;
                    if (got.parent_bits !== due.parent_bits) begin
                        $error("parent_bits: expected %h, got %h",
                               due.parent_bits, got.parent_bits);
                        errors++;
                    end
                    if (got.state_index !== due.state_index) begin
                        $error("state_index: expected %0d, got %0d",
                               due.state_index, got.state_index);
                        errors++;
                    end
                    if (got.score !== due.score) begin
                        $error("score: expected %0d, got %0d", due.score, got.score);
                        errors++;
                    end
                    if (got.score_valid !== due.score_valid) begin
                        $error("score_valid: expected %b, got %b",
                               due.score_valid, got.score_valid);
                        errors++;
                    end
                    if (got.last !== due.last) begin
                        $error("last: expected %b, got %b", due.last, got.last);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("fitch_parsimony_bitvector_top: mismatch");
            $finish;
        end
    end

    // result side: random stall before each word
    initial begin : sink
        int gap;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            gap = no_stall ? 0 : $urandom_range(0, 8);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            @(negedge aclk);
        end
    end

    task automatic send_word(input site_word_t w, input logic pinned,
                             input logic [31:0] pin_score);
        int gap;
        gap = no_stall ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= w.req;
        s_tlast <= w.word_last;
        s_tdata <= {w.right_cost, w.left_cost, w.right_bits, w.left_bits};
        score_pins.push_back('{pinned, pin_score});
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        @(negedge aclk);
    endtask

    // edge positions before the last of a vector make no result, so give the block time to finish one
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (parent_words_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [31:0] random_sites();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom() & $urandom() & $urandom();
            3: return $urandom() | $urandom();
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] random_cost();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return $urandom_range(0, 2000);
        endcase
    endfunction

    function automatic site_word_t random_site_word();
        site_word_t w;
        w.req = 1'($urandom_range(0, 1));
        w.left_bits = random_sites();
        w.right_bits = random_sites();
        w.word_last = 1'($urandom_range(0, 1));
        w.left_cost = random_cost();
        w.right_cost = random_cost();
        return w;
    endfunction

    // one vector of 1 to 3 word positions; a few vectors carry junk flags throughout
    task automatic send_vector(input int n_eff, inout int sent);
        site_word_t w;
        int         positions;
        logic       kind;
        bit         junk;
        positions = $urandom_range(1, 3);
        kind = 1'($urandom_range(0, 1));
        junk = ($urandom_range(0, 7) == 0);
        for (int p = 0; p < positions; p++) begin
            for (int s = 0; s < n_eff; s++) begin
                w = random_site_word();
                if (s == n_eff - 1 && !junk) begin
                    w.req = ($urandom_range(0, 9) == 0) ? ~kind : kind;
                    w.word_last = (p == positions - 1);
                end
                send_word(w, 1'b0, 32'h0);
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        site_word_t  w;
        int          n_eff;
        int          sent;
        logic [31:0] value;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].w, directed_rows[i].pinned, directed_rows[i].pin_score);
        wait_drained();

        // state count lowered below the words already stored in a position
        for (int i = 0; i < 3; i++) begin
            w = random_site_word();
            send_word(w, 1'b0, 32'h0);
        end
        wait_drained();
        write_reg(REG_NUM_STATES, 32'd2);
        settings_used++;
        w = random_site_word();
        w.req = REQ_UPDATE;
        w.word_last = 1'b1;
        send_word(w, 1'b0, 32'h0);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            value = $urandom();
            value[4:0] = (p == PHASES - 1) ? 5'($urandom_range(2, 19)) : phase_states[p];
            n_eff = (value[4:0] < 2) ? 2 : ((value[4:0] > STATES_MAX_DEF) ? STATES_MAX_DEF
                                                                        : int'(value[4:0]));
            write_reg(REG_NUM_STATES, value);
            value = (p == 0) ? 32'hFFFF_FFFF : ((p == 1) ? 32'h0 : $urandom());
            write_reg(REG_CONST_COST, value);
            settings_used++;
            no_stall = (p == 2) || ($urandom_range(0, 4) == 0);
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
                send_vector(n_eff, sent);
            wait_drained();
        end

        $display("sent %0d site words over %0d register settings (2 to 20 states)",
                 words_sent, settings_used);
        $display("checked %0d parent/score words, %0d of them carrying a score",
                 words_checked, scores_checked);
        if (errors == 0) begin
            $display("fitch_parsimony_bitvector_top: match");
        end else begin
            $display("fitch_parsimony_bitvector_top: mismatch");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/fpb_pkg.sv
hw/rtl/fpb_store.sv
hw/rtl/fitch_parsimony_bitvector_top.sv
tb/sv/tb_fitch_parsimony_bitvector_top.sv
